[hw/rtl/tbgb_pkg.sv]
// Shared package for the triangle bounding-box grid binning block.
// Holds sizes, the mode codes and the sequencer state type; depends on nothing.
package tbgb_pkg;
    localparam int MaxRows      = 64;
    localparam int MaxCols      = 64;
    localparam int GridCells    = 4096;
    localparam int ListDepth    = 16;
    localparam int MaxNodes     = 1024;
    localparam int MaxTriangles = 65535;

    localparam int CellW  = $clog2(GridCells);
    localparam int SlotW  = $clog2(ListDepth);
    localparam int FillW  = $clog2(ListDepth + 1);
    localparam int NodeW  = $clog2(MaxNodes);
    localparam int TriW   = 16;
    localparam int CoordW = 24;
    localparam int GridW  = 7;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_BIN   = 2'd1,
        MODE_READ  = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_RDA    = 12'b000000000010,
        S_RDB    = 12'b000000000100,
        S_RDC    = 12'b000000001000,
        S_ACC    = 12'b000000010000,
        S_BOX    = 12'b000000100000,
        S_FRD    = 12'b000001000000,
        S_FWR    = 12'b000010000000,
        S_RRD    = 12'b000100000000,
        S_RLST   = 12'b001000000000,
        S_OUT    = 12'b010000000000,
        S_CLR    = 12'b100000000000
    } t_state;

    // Floor and ceiling of a Q15.8 value to whole grid units (arithmetic shifts).
    function automatic logic signed [15:0] floor_q8(input logic signed [CoordW-1:0] v);
        floor_q8 = v[CoordW-1:8];
    endfunction

    function automatic logic signed [16:0] ceil_q8(input logic signed [CoordW-1:0] v);
        logic signed [16:0] f;
        f = {v[CoordW-1], v[CoordW-1:8]};
        ceil_q8 = (v[7:0] != 8'd0) ? f + 17'sd1 : f;
    endfunction
endpackage

[hw/rtl/triangle_bbox_grid_binning.sv]
// Top level of the triangle bounding-box grid binning block.
// Uses tbgb_pkg; node, fill and list memories live here under one sequencer.
//
// One beat is taken at a time; a node load leaves the sequencer idle. A read
// holds the input off through S_RRD, S_RLST and S_OUT, then until its result
// beat is taken. A triangle steps through S_RDA, S_RDB, S_RDC, S_ACC and S_BOX
// to fetch its nodes and form the box, then through S_FRD and S_FWR for each
// covered cell, as the fill memory is read and then written per cell. A clear,
// and the reset pass, sweep the fill memory one entry a cycle, taking no beat.
module triangle_bbox_grid_binning (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [6:0]           i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_mode,
    input  logic [9:0]           i_node_index,
    input  logic signed [23:0]   i_coord_x,
    input  logic signed [23:0]   i_coord_y,
    input  logic [9:0]           i_vertex_a,
    input  logic [9:0]           i_vertex_b,
    input  logic [9:0]           i_vertex_c,
    input  logic [11:0]          i_cell_index,
    input  logic [3:0]           i_slot,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [15:0]          o_stored_triangle,
    output logic [4:0]           o_entries_in_cell,
    output logic [4:0]           o_max_entries,
    output logic                 o_overflowed
);
    localparam int CW = tbgb_pkg::CellW;
    localparam int SW = tbgb_pkg::SlotW;
    localparam int FW = tbgb_pkg::FillW;
    localparam int NW = tbgb_pkg::NodeW;
    localparam int TW = tbgb_pkg::TriW;
    localparam int XW = tbgb_pkg::CoordW;

    logic [XW-1:0] m_nx [tbgb_pkg::MaxNodes];
    logic [XW-1:0] m_ny [tbgb_pkg::MaxNodes];
    logic [FW-1:0] m_fill [tbgb_pkg::GridCells];
    logic [TW-1:0] m_list [tbgb_pkg::GridCells * tbgb_pkg::ListDepth];

    tbgb_pkg::t_state r_state, n_state;
    logic [6:0]  r_len, r_wid;
    logic [TW-1:0] r_tri;
    logic [FW-1:0] r_max;
    logic        r_ovf;
    logic [NW-1:0] r_va, r_vb, r_vc;
    logic [CW-1:0] r_rcell;
    logic [SW-1:0] r_rslot;
    logic        r_rslot_ok;
    logic signed [XW-1:0] r_nx, r_ny;
    logic signed [XW-1:0] r_xmin, r_xmax, r_ymin, r_ymax;
    logic [6:0]  r_x, r_y, r_xr, r_yl, r_yr, r_l;
    logic [CW:0] r_cell;
    logic [FW-1:0] r_fill;
    logic [TW-1:0] r_lst;
    logic [CW:0] r_clr;
    logic        r_ov;
    logic [TW-1:0] r_otri;
    logic [FW-1:0] r_ofill;

    logic acc_in;
    // A read result waiting at the output holds the input off as well.
    assign o_stall = (r_state != tbgb_pkg::S_IDLE) || r_ov;
    assign acc_in  = i_valid && !o_stall;

    // Effective grid sizes after clamping to the physical extent.
    logic [6:0] w_eff, l_eff;
    assign w_eff = (r_wid > 7'(tbgb_pkg::MaxCols)) ? 7'(tbgb_pkg::MaxCols) : r_wid;
    assign l_eff = (r_len > 7'(tbgb_pkg::MaxRows)) ? 7'(tbgb_pkg::MaxRows) : r_len;

    // Box bounds from the accumulated extremes.
    logic signed [15:0] fxl, fyl;
    logic signed [16:0] cxr, cyr;
    logic box_empty;
    logic [6:0] bxl, bxr, byl, byr;
    always_comb begin
        fxl = tbgb_pkg::floor_q8(r_xmin);
        fyl = tbgb_pkg::floor_q8(r_ymin);
        cxr = tbgb_pkg::ceil_q8(r_xmax);
        cyr = tbgb_pkg::ceil_q8(r_ymax);
        bxl = (fxl < 16'sd1) ? 7'd1 : ((fxl > 16'sd64) ? 7'd65 : 7'(fxl));
        byl = (fyl < 16'sd1) ? 7'd1 : ((fyl > 16'sd64) ? 7'd65 : 7'(fyl));
        bxr = (cxr > $signed({10'd0, w_eff})) ? w_eff : ((cxr < 17'sd0) ? 7'd0 : 7'(cxr));
        byr = (cyr > $signed({10'd0, l_eff})) ? l_eff : ((cyr < 17'sd0) ? 7'd0 : 7'(cyr));
        box_empty = (bxl > bxr) || (byl > byr);
    end

    // Cell address of the current box position: (y-1) + l*(x-1).
    logic [13:0] cell_calc;
    assign cell_calc = 14'(r_y - 7'd1) + 14'(r_l) * 14'(r_x - 7'd1);

    logic last_cell;
    assign last_cell = (r_x == r_xr) && (r_y == r_yr);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tbgb_pkg::S_IDLE: begin
                if (acc_in) begin
                    unique case (tbgb_pkg::t_mode'(i_mode))
                        tbgb_pkg::MODE_LOAD:  n_state = tbgb_pkg::S_IDLE;
                        tbgb_pkg::MODE_BIN:   n_state =
                            (r_tri >= TW'(tbgb_pkg::MaxTriangles)) ? tbgb_pkg::S_IDLE
                                                                  : tbgb_pkg::S_RDA;
                        tbgb_pkg::MODE_READ:  n_state = tbgb_pkg::S_RRD;
                        tbgb_pkg::MODE_CLEAR: n_state = tbgb_pkg::S_CLR;
                        default:              n_state = tbgb_pkg::S_IDLE;
                    endcase
                end
            end
            tbgb_pkg::S_RDA: n_state = tbgb_pkg::S_RDB;
            tbgb_pkg::S_RDB: n_state = tbgb_pkg::S_RDC;
            tbgb_pkg::S_RDC: n_state = tbgb_pkg::S_ACC;
            tbgb_pkg::S_ACC: n_state = tbgb_pkg::S_BOX;
            tbgb_pkg::S_BOX: n_state = box_empty ? tbgb_pkg::S_IDLE : tbgb_pkg::S_FRD;
            tbgb_pkg::S_FRD: n_state = tbgb_pkg::S_FWR;
            tbgb_pkg::S_FWR: n_state = last_cell ? tbgb_pkg::S_IDLE : tbgb_pkg::S_FRD;
            tbgb_pkg::S_RRD: n_state = tbgb_pkg::S_RLST;
            tbgb_pkg::S_RLST: n_state = tbgb_pkg::S_OUT;
            tbgb_pkg::S_OUT: n_state = tbgb_pkg::S_IDLE;
            tbgb_pkg::S_CLR:
                n_state = (r_clr == (CW+1)'(tbgb_pkg::GridCells - 1)) ? tbgb_pkg::S_IDLE
                                                                      : tbgb_pkg::S_CLR;
            default: n_state = tbgb_pkg::S_IDLE;
        endcase
    end

    // Node memories.
    always_ff @(posedge i_clk) begin
        if (acc_in && tbgb_pkg::t_mode'(i_mode) == tbgb_pkg::MODE_LOAD) begin
            m_nx[i_node_index] <= i_coord_x;
            m_ny[i_node_index] <= i_coord_y;
        end
    end

    logic [NW-1:0] node_addr;
    always_comb begin
        priority case (1'b1)
            r_state == tbgb_pkg::S_RDB: node_addr = r_vb;
            r_state == tbgb_pkg::S_RDC: node_addr = r_vc;
            default:                    node_addr = r_va;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_nx <= m_nx[node_addr];
        r_ny <= m_ny[node_addr];
    end

    // Fill memory: one read and one write port, cleared by sweep.
    logic [CW-1:0] fill_raddr;
    assign fill_raddr = (r_state == tbgb_pkg::S_FRD) ? cell_calc[CW-1:0] : r_rcell;
    always_ff @(posedge i_clk) begin
        r_fill <= m_fill[fill_raddr];
        if (r_state == tbgb_pkg::S_CLR)
            m_fill[r_clr[CW-1:0]] <= '0;
        else if (r_state == tbgb_pkg::S_FWR && !r_cell[CW] &&
                 r_fill < FW'(tbgb_pkg::ListDepth))
            m_fill[r_cell[CW-1:0]] <= r_fill + FW'(1);
    end

    // List memory.
    always_ff @(posedge i_clk) begin
        if (r_state == tbgb_pkg::S_FWR && !r_cell[CW] &&
            r_fill < FW'(tbgb_pkg::ListDepth))
            m_list[{r_cell[CW-1:0], r_fill[SW-1:0]}] <= r_tri;
        r_lst <= m_list[{r_rcell, r_rslot}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbgb_pkg::S_CLR;
            r_clr   <= '0;
            r_len   <= 7'd64;
            r_wid   <= 7'd64;
            r_tri   <= '0;
            r_max   <= '0;
            r_ovf   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index) r_wid <= i_cfg_data;
                else             r_len <= i_cfg_data;
            end
            if (r_state == tbgb_pkg::S_CLR) r_clr <= r_clr + (CW+1)'(1);
            if (acc_in) begin
                r_clr <= '0;
                if (tbgb_pkg::t_mode'(i_mode) == tbgb_pkg::MODE_BIN &&
                    r_tri < TW'(tbgb_pkg::MaxTriangles))
                    r_tri <= r_tri + TW'(1);
                if (tbgb_pkg::t_mode'(i_mode) == tbgb_pkg::MODE_CLEAR) begin
                    r_tri <= '0;
                    r_max <= '0;
                    r_ovf <= 1'b0;
                end
            end
            if (r_state == tbgb_pkg::S_FWR && !r_cell[CW]) begin
                if (r_fill >= FW'(tbgb_pkg::ListDepth)) r_ovf <= 1'b1;
                else if (r_fill + FW'(1) > r_max)       r_max <= r_fill + FW'(1);
            end
            if (r_state == tbgb_pkg::S_OUT) r_ov <= 1'b1;
            else if (r_ov && !i_stall)      r_ov <= 1'b0;
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_va <= i_vertex_a;
            r_vb <= i_vertex_b;
            r_vc <= i_vertex_c;
            r_rcell <= i_cell_index;
            r_rslot <= i_slot;
        end
        unique case (r_state)
            tbgb_pkg::S_RDB: begin
                r_xmin <= r_nx; r_xmax <= r_nx; r_ymin <= r_ny; r_ymax <= r_ny;
            end
            tbgb_pkg::S_RDC, tbgb_pkg::S_ACC: begin
                if (r_nx < r_xmin) r_xmin <= r_nx;
                if (r_nx > r_xmax) r_xmax <= r_nx;
                if (r_ny < r_ymin) r_ymin <= r_ny;
                if (r_ny > r_ymax) r_ymax <= r_ny;
            end
            tbgb_pkg::S_BOX: begin
                r_xr <= bxr; r_yl <= byl; r_yr <= byr;
                r_x <= bxl; r_y <= byl; r_l <= l_eff;
                r_cell <= 13'(14'(byl - 7'd1) + 14'(l_eff) * 14'(bxl - 7'd1));
            end
            tbgb_pkg::S_FWR: begin
                if (r_y == r_yr) begin
                    r_y <= r_yl;
                    r_x <= r_x + 7'd1;
                end else begin
                    r_y <= r_y + 7'd1;
                end
            end
            tbgb_pkg::S_FRD: r_cell <= (cell_calc >= 14'(tbgb_pkg::GridCells))
                                       ? {1'b1, CW'(0)} : 13'(cell_calc);
            tbgb_pkg::S_RLST: r_rslot_ok <= (r_rslot < SW'(r_fill)) ||
                                            (r_fill >= FW'(tbgb_pkg::ListDepth));
            tbgb_pkg::S_OUT: begin
                r_otri  <= r_rslot_ok ? r_lst : '0;
                r_ofill <= r_fill;
            end
            default: ;
        endcase
    end

    // The fill read in S_FRD is addressed from the walk position, and r_cell
    // keeps that address for the write in S_FWR.
    assign o_valid           = r_ov;
    assign o_stored_triangle = r_otri;
    assign o_entries_in_cell = r_ofill;
    assign o_max_entries     = r_max;
    assign o_overflowed      = r_ovf;

    ap_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != tbgb_pkg::S_IDLE) |-> o_stall)
        else $error("beat taken while busy");
    ap_max_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_max <= FW'(tbgb_pkg::ListDepth))
        else $error("largest fill beyond list depth");
    ap_out_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tbgb_pkg::S_OUT) |=> o_valid)
        else $error("read result not presented");
    ap_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_stored_triangle) &&
                                  $stable(o_entries_in_cell)))
        else $error("stalled result beat changed");
endmodule

[tb/tb_triangle_bbox_grid_binning.sv]
// Self-checking testbench for the triangle bounding-box grid binning block.
// Depends on tbgb_pkg and triangle_bbox_grid_binning; predicts every read beat.
module tb_triangle_bbox_grid_binning;

    typedef struct packed {
        logic [1:0]         mode;
        logic [9:0]         node_index;
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic [9:0]         va;
        logic [9:0]         vb;
        logic [9:0]         vc;
        logic [11:0]        cell_no;
        logic [3:0]         slot;
    } t_beat;

    typedef struct packed {
        logic [15:0] tri_num;
        logic [4:0]  fill;
        logic [4:0]  max_fill;
        logic        ovf;
    } t_readout;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_index = 1'b0;
    logic [6:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_mode = '0;
    logic [9:0] i_node_index = '0;
    logic signed [23:0] i_coord_x = '0;
    logic signed [23:0] i_coord_y = '0;
    logic [9:0] i_vertex_a = '0;
    logic [9:0] i_vertex_b = '0;
    logic [9:0] i_vertex_c = '0;
    logic [11:0] i_cell_index = '0;
    logic [3:0] i_slot = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [15:0] o_stored_triangle;
    logic [4:0] o_entries_in_cell;
    logic [4:0] o_max_entries;
    logic o_overflowed;

    triangle_bbox_grid_binning dut (.*);

    // Predictor state.
    logic signed [23:0] node_x [tbgb_pkg::MaxNodes];
    logic signed [23:0] node_y [tbgb_pkg::MaxNodes];
    bit                 node_loaded [tbgb_pkg::MaxNodes];
    logic [4:0]         cell_fill [tbgb_pkg::GridCells];
    logic [15:0]        cell_list [tbgb_pkg::GridCells*tbgb_pkg::ListDepth];
    logic [4:0]         peak_fill;
    logic [15:0]        tri_count;
    logic               ovf_flag;
    int unsigned        rows_cfg = 64;
    int unsigned        cols_cfg = 64;

    t_beat    pending_beats[$];
    t_readout expected_reads[$];
    int       errors = 0;
    int       cycle = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       hold_off = 0;

    function automatic int floor8(logic signed [23:0] v);
        return v >>> 8;
    endfunction

    function automatic int ceil8(logic signed [23:0] v);
        return (v >>> 8) + ((v[7:0] != 0) ? 1 : 0);
    endfunction

    function automatic int min3(int a, int b, int c);
        int m;
        m = a < b ? a : b;
        return m < c ? m : c;
    endfunction

    function automatic int max3(int a, int b, int c);
        int m;
        m = a > b ? a : b;
        return m > c ? m : c;
    endfunction

    task automatic predict_beat(input t_beat b);
        int xl, xr, yl, yr, w, l, cidx;
        t_readout r;
        case (tbgb_pkg::t_mode'(b.mode))
            tbgb_pkg::MODE_LOAD: begin
                node_x[b.node_index] = b.cx;
                node_y[b.node_index] = b.cy;
                node_loaded[b.node_index] = 1;
            end
            tbgb_pkg::MODE_BIN: begin
                if (tri_count < tbgb_pkg::MaxTriangles) begin
                    tri_count++;
                    w = cols_cfg > tbgb_pkg::MaxCols ? tbgb_pkg::MaxCols : cols_cfg;
                    l = rows_cfg > tbgb_pkg::MaxRows ? tbgb_pkg::MaxRows : rows_cfg;
                    xl = floor8(node_x[b.va]);
                    xl = min3(xl, floor8(node_x[b.vb]), floor8(node_x[b.vc]));
                    xr = max3(ceil8(node_x[b.va]), ceil8(node_x[b.vb]), ceil8(node_x[b.vc]));
                    yl = min3(floor8(node_y[b.va]), floor8(node_y[b.vb]), floor8(node_y[b.vc]));
                    yr = max3(ceil8(node_y[b.va]), ceil8(node_y[b.vb]), ceil8(node_y[b.vc]));
                    if (xl < 1) xl = 1;
                    if (yl < 1) yl = 1;
                    if (xr > w) xr = w;
                    if (yr > l) yr = l;
                    for (int x = xl; x <= xr; x++) begin
                        for (int y = yl; y <= yr; y++) begin
                            cidx = (y - 1) + l * (x - 1);
                            if (cidx < tbgb_pkg::GridCells) begin
                                if (cell_fill[cidx] >= tbgb_pkg::ListDepth) begin
                                    ovf_flag = 1;
                                end else begin
                                    cell_list[cidx*tbgb_pkg::ListDepth + cell_fill[cidx]] =
                                        tri_count;
                                    cell_fill[cidx]++;
                                    if (cell_fill[cidx] > peak_fill) peak_fill = cell_fill[cidx];
                                end
                            end
                        end
                    end
                end
            end
            tbgb_pkg::MODE_READ: begin
                r.fill = cell_fill[b.cell_no];
                r.tri_num = (b.slot < r.fill) ?
                            cell_list[b.cell_no*tbgb_pkg::ListDepth + b.slot] : 16'd0;
                r.max_fill = peak_fill;
                r.ovf = ovf_flag;
                expected_reads.push_back(r);
            end
            default: begin
                foreach (cell_fill[i]) cell_fill[i] = '0;
                peak_fill = '0;
                tri_count = '0;
                ovf_flag = 1'b0;
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle);
        errors++;
    endtask

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > 10000000) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Driver: beats are predicted when they are accepted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) predict_beat(pending_beats.pop_front());
            if ((!i_valid || !o_stall)) begin
                if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct
                    && !(i_valid && !o_stall && pending_beats.size() == 0)) begin
                    i_valid <= 1'b1;
                    i_mode <= pending_beats[0].mode;
                    i_node_index <= pending_beats[0].node_index;
                    i_coord_x <= pending_beats[0].cx;
                    i_coord_y <= pending_beats[0].cy;
                    i_vertex_a <= pending_beats[0].va;
                    i_vertex_b <= pending_beats[0].vb;
                    i_vertex_c <= pending_beats[0].vc;
                    i_cell_index <= pending_beats[0].cell_no;
                    i_slot <= pending_beats[0].slot;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver stall.
    always @(posedge i_clk) begin
        t_readout w;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_reads.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    w = expected_reads.pop_front();
                    if (o_stored_triangle !== w.tri_num)
                        report_mismatch("stored_triangle", o_stored_triangle, w.tri_num);
                    if (o_entries_in_cell !== w.fill)
                        report_mismatch("entries_in_cell", o_entries_in_cell, w.fill);
                    if (o_max_entries !== w.max_fill)
                        report_mismatch("max_entries", o_max_entries, w.max_fill);
                    if (o_overflowed !== w.ovf)
                        report_mismatch("overflowed", o_overflowed, w.ovf);
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    function automatic t_beat blank_beat();
        t_beat b;
        b = '0;
        b.mode = 2'($urandom);
        b.node_index = 10'($urandom);
        b.cx = 24'($urandom);
        b.cy = 24'($urandom);
        b.cell_no = 12'($urandom);
        b.slot = 4'($urandom);
        return b;
    endfunction

    task automatic queue_load(input int n, input int cx, input int cy);
        t_beat b;
        b = blank_beat();
        b.mode = tbgb_pkg::MODE_LOAD;
        b.node_index = 10'(n);
        b.cx = 24'(cx);
        b.cy = 24'(cy);
        node_loaded[n] = 1;
        pending_beats.push_back(b);
    endtask

    task automatic queue_bin(input int a, input int bb, input int c);
        t_beat b;
        b = blank_beat();
        b.mode = tbgb_pkg::MODE_BIN;
        b.va = 10'(a);
        b.vb = 10'(bb);
        b.vc = 10'(c);
        pending_beats.push_back(b);
    endtask

    task automatic queue_read(input int cell_no, input int s);
        t_beat b;
        b = blank_beat();
        b.mode = tbgb_pkg::MODE_READ;
        b.cell_no = 12'(cell_no);
        b.slot = 4'(s);
        pending_beats.push_back(b);
    endtask

    task automatic queue_clear();
        t_beat b;
        b = blank_beat();
        b.mode = tbgb_pkg::MODE_CLEAR;
        pending_beats.push_back(b);
    endtask

    // Waits for the queue, all reads and the block itself to go idle.
    task automatic wait_idle();
        while (pending_beats.size() > 0 || i_valid || expected_reads.size() > 0 || o_stall)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input bit idx, input int val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 7'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == 0) rows_cfg = val; else cols_cfg = val;
    endtask

    // Small coordinate near the grid, in Q15.8, often on a whole unit.
    function automatic int rand_coord(input int span);
        int v;
        v = $urandom_range(span * 256 + 512) - 256;
        if ($urandom_range(3) == 0) v = v & ~32'hFF;
        return v;
    endfunction

    task automatic random_phase(input int count, input int rows, input int cols);
        int a, bb, c, pick;
        for (int k = 0; k < 24; k++) begin
            queue_load(k, rand_coord(cols), rand_coord(rows));
        end
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                a = $urandom_range(1023);
                if ($urandom_range(3) == 0)
                    queue_load(a, $urandom, $urandom);
                else
                    queue_load(a, rand_coord(cols), rand_coord(rows));
            end else if (pick < 45) begin
                // Vertices only from loaded nodes; small boxes mostly.
                do a = $urandom_range(1023); while (!node_loaded[a]);
                do bb = $urandom_range(1023); while (!node_loaded[bb]);
                do c = $urandom_range(1023); while (!node_loaded[c]);
                queue_bin(a, bb, c);
            end else if (pick < 98) begin
                if ($urandom_range(9) == 0)
                    queue_read($urandom_range(4095), $urandom_range(15));
                else
                    queue_read($urandom_range(rows * cols - 1), $urandom_range(15));
            end else begin
                queue_clear();
            end
        end
    endtask

    initial begin
        foreach (cell_fill[i]) cell_fill[i] = '0;
        foreach (node_loaded[i]) node_loaded[i] = 0;
        peak_fill = '0;
        tri_count = '0;
        ovf_flag = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4200) @(posedge i_clk);

        // Directed: corners, extremes, clamping and overflow of four cells.
        send_idle_pct = 22;
        recv_idle_pct = 73;
        queue_load(0, 24'sh7FFFFF, 24'sh7FFFFF);
        queue_load(1, -24'sd8388608, -24'sd8388608);
        queue_load(1023, 24'sd256, 24'sd256);
        queue_load(2, 24'sd384, 24'sd300);
        queue_load(3, 24'sd257, 24'sd511);
        queue_bin(0, 1, 1023);
        queue_bin(1023, 1023, 1023);
        queue_bin(1, 1, 1);
        queue_bin(0, 0, 0);
        for (int k = 0; k < 17; k++) queue_bin(2, 3, 1023);
        queue_read(0, 0);
        queue_read(0, 15);
        queue_read(4095, 3);
        queue_read(64, 1);
        queue_clear();
        queue_read(0, 0);
        wait_idle();

        write_reg(0, 127);
        write_reg(1, 0);
        queue_bin(0, 1, 2);
        queue_read(0, 0);
        wait_idle();
        write_reg(0, 1);
        write_reg(1, 1);
        queue_bin(0, 1, 2);
        queue_read(0, 0);
        queue_clear();
        wait_idle();

        // Long receiver hold-off with the sender still offering beats.
        hold_off = 600;
        write_reg(0, 8);
        write_reg(1, 5);
        random_phase(270, 8, 5);
        wait_idle();

        send_idle_pct = 73;
        recv_idle_pct = 22;
        write_reg(0, 64);
        write_reg(1, 64);
        random_phase(320, 6, 6);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(0, 3);
        write_reg(1, 127);
        random_phase(350, 3, 10);
        wait_idle();

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
